// ----- src/rbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg: shared types, constants and arithmetic for the row smoother.
// Holds the word formats, register indexes and the weighted-sum helper.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned MAX_ROW = 1024;
  localparam int unsigned DEPTH   = MAX_ROW + 2;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned CELL_W  = 96;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  localparam logic [1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [1:0] CFG_PASSES     = 2'd1;
  localparam logic [1:0] CFG_COMPENSATE = 2'd2;
  localparam logic [1:0] CFG_PERIODIC   = 2'd3;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [10:0]        cell_index;
    logic signed [31:0] jx;
    logic signed [31:0] jy;
    logic signed [31:0] jz;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] jx_out;
    logic signed [31:0] jy_out;
    logic signed [31:0] jz_out;
    logic               index_error;
  } out_word_t;

  // Weighted sum in quarters, rounded half up and saturated to 32 bits.
  function automatic logic signed [31:0] smooth(
    input logic signed [31:0] a,
    input logic signed [31:0] b,
    input logic signed [31:0] c,
    input logic signed [5:0]  wa,
    input logic signed [6:0]  wb
  );
    logic signed [32:0] sum_ac;
    logic signed [41:0] s;
    logic signed [41:0] q;
    sum_ac = 33'(a) + 33'(c);
    s      = 42'(wa) * 42'(sum_ac) + 42'(wb) * 42'(b);
    q      = (s + 42'sd2) >>> 2;
    if (q > 42'sd2147483647) begin
      smooth = 32'sh7FFFFFFF;
    end else if (q < -42'sd2147483648) begin
      smooth = 32'sh80000000;
    end else begin
      smooth = q[31:0];
    end
  endfunction

endpackage

// ----- src/rbs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_ram: generic simple dual-port RAM.
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/row_binomial_smoother_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_binomial_smoother_top: multipass binomial row smoother.
// Keeps one row of three-component cells in a RAM and smooths it in place.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Word
// in        input      in_valid_i / in_stall_o  rbs_pkg::in_word_t
// out       output     out_valid_o / out_stall_i rbs_pkg::out_word_t
// cfg       input      cfg_we_i (no wait)       cfg_idx_i, cfg_data_i
//
// A write goes into the RAM at its accept. A read passes two registers: the RAM read data is
// registered and then loaded into the output register.
// A run keeps the block busy from its accept through P passes and C, the
// optional compensator pass taken only when P is nonzero, then loads the finish
// word once the output register is free; each pass streams the row once through
// the single RAM read port, plus two ghost writes when periodic.
// Reset clears the control state; the row RAM itself is not cleared.
// A stalled result holds the output register; new words are stalled only
// while it is full and stalled, or while a read or run is in flight.
// ----------------------------------------------------------------------------
module row_binomial_smoother_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rbs_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbs_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_GH0   = 5'b00100,
    ST_GH1   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [10:0] row_length_q;
  logic [3:0]  passes_q;
  logic        compensate_q;
  logic        periodic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= 11'd1024;
      passes_q     <= 4'd1;
      compensate_q <= 1'b0;
      periodic_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbs_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_data_i;
        rbs_pkg::CFG_PASSES:     passes_q     <= cfg_data_i[3:0];
        rbs_pkg::CFG_COMPENSATE: compensate_q <= cfg_data_i[0];
        rbs_pkg::CFG_PERIODIC:   periodic_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective row length, clamped to 1..MAX_ROW.
  logic [rbs_pkg::CNT_W-1:0] len;
  logic [rbs_pkg::CNT_W-1:0] last_idx;
  always_comb begin
    if (row_length_q == 11'd0) begin
      len = rbs_pkg::CNT_W'(1);
    end else if (rbs_pkg::CNT_W'(row_length_q) > rbs_pkg::CNT_W'(rbs_pkg::MAX_ROW)) begin
      len = rbs_pkg::CNT_W'(rbs_pkg::MAX_ROW);
    end else begin
      len = rbs_pkg::CNT_W'(row_length_q);
    end
    last_idx = len + rbs_pkg::CNT_W'(1);
  end

  // Total pass count, and the weights of the current pass.
  logic [4:0]        total;
  logic [4:0]        pass_q, pass_d;
  logic              is_comp;
  logic signed [5:0] wa;
  logic signed [6:0] wb;
  assign total   = 5'(passes_q) + 5'(compensate_q && (passes_q != 4'd0));
  assign is_comp = (pass_q == 5'(passes_q));
  assign wa      = is_comp ? -$signed(6'(passes_q)) : 6'sd1;
  assign wb      = is_comp ? $signed(7'(passes_q) * 7'd2 + 7'd4) : 7'sd2;

  // Request decode.
  logic in_acc;
  logic idx_ok;
  assign in_acc = in_valid_i && !in_stall_o;
  assign idx_ok = rbs_pkg::CNT_W'(in_data_i.cell_index) <= last_idx;

  // Sweep bookkeeping.
  logic [rbs_pkg::CNT_W-1:0]  ra_q, ra_d;
  logic                       rv_q;
  logic [rbs_pkg::CNT_W-1:0]  da_q;
  logic [rbs_pkg::CELL_W-1:0] prev_q, prev_d, cur_q, cur_d;
  logic [rbs_pkg::CELL_W-1:0] first_q, first_d, last_q, last_d;
  logic                       issue;

  // Pending user read.
  logic rd_pend_q, rd_err_q;

  // Output register.
  rbs_pkg::out_word_t out_q, out_d;
  logic               out_vld_q, out_vld_d;
  logic               out_free;
  assign out_free = !out_vld_q || !out_stall_i;

  // RAM.
  logic                       we;
  logic [rbs_pkg::ADDR_W-1:0] waddr, raddr;
  logic [rbs_pkg::CELL_W-1:0] wdata, rdata, res;

  rbs_ram #(
    .WIDTH(rbs_pkg::CELL_W),
    .DEPTH(rbs_pkg::DEPTH)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // New cell value from original left, centre and right neighbours.
  always_comb begin
    res[95:64] = rbs_pkg::smooth(prev_q[95:64], cur_q[95:64], rdata[95:64], wa, wb);
    res[63:32] = rbs_pkg::smooth(prev_q[63:32], cur_q[63:32], rdata[63:32], wa, wb);
    res[31:0]  = rbs_pkg::smooth(prev_q[31:0],  cur_q[31:0],  rdata[31:0],  wa, wb);
  end

  assign in_stall_o = (state_q != ST_IDLE) || rd_pend_q || (out_vld_q && out_stall_i);
  assign issue      = (state_q == ST_SWEEP) && (ra_q <= last_idx);

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    ra_d      = ra_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    first_d   = first_q;
    last_d    = last_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    we        = 1'b0;
    waddr     = in_data_i.cell_index[rbs_pkg::ADDR_W-1:0];
    wdata     = {in_data_i.jx, in_data_i.jy, in_data_i.jz};
    raddr     = in_data_i.cell_index[rbs_pkg::ADDR_W-1:0];

    // A user read is pending after its accept; the registered RAM data is then loaded into the output register.
    if (rd_pend_q) begin
      out_vld_d          = 1'b1;
      out_d.result_kind  = rbs_pkg::KIND_READ;
      out_d.index_error  = rd_err_q;
      out_d.jx_out       = rd_err_q ? 32'sd0 : rdata[95:64];
      out_d.jy_out       = rd_err_q ? 32'sd0 : rdata[63:32];
      out_d.jz_out       = rd_err_q ? 32'sd0 : rdata[31:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_data_i.req_type == rbs_pkg::REQ_WRITE) begin
            we = idx_ok;
          end else if (in_data_i.req_type == rbs_pkg::REQ_RUN) begin
            pass_d  = 5'd0;
            ra_d    = '0;
            state_d = (total == 5'd0) ? ST_DONE : ST_SWEEP;
          end else begin
          end
        end
      end
      ST_SWEEP: begin
        raddr = ra_q[rbs_pkg::ADDR_W-1:0];
        if (issue) begin
          ra_d = ra_q + rbs_pkg::CNT_W'(1);
        end
        if (rv_q) begin
          priority if (da_q == '0) begin
            prev_d = rdata;
          end else if (da_q == rbs_pkg::CNT_W'(1)) begin
            cur_d = rdata;
          end else begin
            we     = 1'b1;
            waddr  = rbs_pkg::ADDR_W'(da_q - rbs_pkg::CNT_W'(1));
            wdata  = res;
            prev_d = cur_q;
            cur_d  = rdata;
            last_d = res;
            if (da_q == rbs_pkg::CNT_W'(2)) begin
              first_d = res;
            end
            if (da_q == last_idx) begin
              if (periodic_q) begin
                state_d = ST_GH0;
              end else begin
                pass_d  = pass_q + 5'd1;
                ra_d    = '0;
                state_d = (pass_q + 5'd1 == total) ? ST_DONE : ST_SWEEP;
              end
            end
          end
        end
      end
      ST_GH0: begin
        // Left ghost takes the new last interior cell.
        we      = 1'b1;
        waddr   = '0;
        wdata   = last_q;
        state_d = ST_GH1;
      end
      ST_GH1: begin
        // Right ghost takes the new first interior cell.
        we      = 1'b1;
        waddr   = rbs_pkg::ADDR_W'(last_idx);
        wdata   = first_q;
        pass_d  = pass_q + 5'd1;
        ra_d    = '0;
        state_d = (pass_q + 5'd1 == total) ? ST_DONE : ST_SWEEP;
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          out_d.result_kind = rbs_pkg::KIND_DONE;
          out_d.jx_out      = 32'sd0;
          out_d.jy_out      = 32'sd0;
          out_d.jz_out      = 32'sd0;
          out_d.index_error = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pass_q    <= '0;
      ra_q      <= '0;
      rv_q      <= 1'b0;
      da_q      <= '0;
      rd_pend_q <= 1'b0;
      rd_err_q  <= 1'b0;
      out_vld_q <= 1'b0;
      prev_q    <= '0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      ra_q      <= ra_d;
      rv_q      <= issue;
      da_q      <= ra_q;
      rd_pend_q <= in_acc && (in_data_i.req_type == rbs_pkg::REQ_READ);
      rd_err_q  <= !idx_ok;
      out_vld_q <= out_vld_d;
      prev_q    <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    first_q <= first_d;
    last_q  <= last_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
